@@ src/ssmsd_pkg.sv @@
// shared constants, types and segment table for the seven-segment serial driver
package ssmsd_pkg;

	localparam int DIGITS       = 5;
	localparam int SELECT_LINES = 3;
	localparam int VALUE_W      = 17;
	localparam int SEG_W        = 8;
	localparam int SEL_W        = 3;
	localparam int WORD_W       = DIGITS * SEG_W;
	localparam int DIG_W        = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int CNT_W        = $clog2(DIGITS + 1);
	localparam int BIT_W        = $clog2(SEG_W);

	// divide by ten: x * 104858 >> 20 is exact for every x below 2**18
	localparam int RECIP_W      = 18;
	localparam int RECIP_SHIFT  = 20;
	localparam int PROD_W       = VALUE_W + RECIP_W;
	localparam int QUOT_W       = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 18'd104858;

	localparam logic [SEG_W-1:0] BLANK_PATTERN = 8'hFF;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
		logic [SEG_W-1:0] pat;
		unique case (digit)
			4'd0: pat = 8'hDD;
			4'd1: pat = 8'h44;
			4'd2: pat = 8'hAD;
			4'd3: pat = 8'hEC;
			4'd4: pat = 8'h74;
			4'd5: pat = 8'hF8;
			4'd6: pat = 8'hF9;
			4'd7: pat = 8'h4C;
			4'd8: pat = 8'hFD;
			4'd9: pat = 8'hFC;
			default: pat = BLANK_PATTERN;
		endcase
		return pat;
	endfunction

endpackage

@@ src/seven_segment_mux_shift_driver_unit.sv @@
// top level of the seven-segment serial driver: front end, word queue, bit shifter
// A number on value_to_show is taken when start is high and busy is low. It comes out as
// 40 serial bits, one per clock, each marked by strobe for exactly one cycle: the units
// digit first, each segment pattern msb first, the eighth bit of a digit flagged by
// latch_after with its one-hot select line for the first three digits only, and last on the
// final bit. The shifter in the back end sets the pace of numbers; the front end splits a
// number into its digits and then pushes the word, so busy stays high after a transfer until
// the word is pushed, which waits while the two-word queue is full.
// The queue lets the front end take the next numbers while bits are still going out, so
// strobe stays high across numbers sent back to back.
// With the queue and shifter idle the first bit goes out once the word is pushed and loaded
// into the shifter; otherwise it follows right after the last bit of the numbers ahead.
// There is no way to hold off results, so the receiver must take a bit on every strobe.
module seven_segment_mux_shift_driver_unit import ssmsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [VALUE_W-1:0] value_to_show,
	output logic               strobe,
	output logic               serial_bit,
	output logic               latch_after,
	output logic [SEL_W-1:0]   digit_select,
	output logic               last
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	word_t   push_word;
	word_t   pop_word;

	ssmsd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.value_to_show (value_to_show),
		.q_stat        (q_stat),
		.busy          (busy),
		.push          (push),
		.push_word     (push_word)
	);

	ssmsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.q_stat    (q_stat)
	);

	ssmsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop_word     (pop_word),
		.pop          (pop),
		.strobe       (strobe),
		.serial_bit   (serial_bit),
		.latch_after  (latch_after),
		.digit_select (digit_select),
		.last         (last)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("pop from empty queue");

	a_last_on_latch: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> latch_after)
		else $error("last bit not on a latch point");

	a_sel_only_latch: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !latch_after |-> digit_select == '0)
		else $error("digit select outside latch point");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $onehot0(digit_select))
		else $error("digit select not one-hot");

endmodule

@@ src/ssmsd_front.sv @@
// front end: takes a number, peels off one decimal digit per cycle, builds the pattern word
module ssmsd_front import ssmsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] value_to_show,
	input  q_stat_t            q_stat,
	output logic               busy,
	output logic               push,
	output word_t              push_word
);

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_PUSH
	} front_state_t;

	front_state_t       state_q;
	logic [CNT_W-1:0]   dcnt_q;
	logic [VALUE_W-1:0] rest_q;
	word_t              word_q;

	logic [PROD_W-1:0]  prod;
	logic [QUOT_W-1:0]  quot;
	logic [VALUE_W-1:0] quot_ext;
	logic [VALUE_W-1:0] tens;
	logic [3:0]         digit;

	always_comb begin
		prod     = PROD_W'(rest_q) * PROD_W'(RECIP_TEN);
		quot     = prod[PROD_W-1:RECIP_SHIFT];
		quot_ext = VALUE_W'(quot);
		tens     = (quot_ext << 3) + (quot_ext << 1);
		digit    = 4'(rest_q - tens);
	end

	assign busy      = (state_q != F_IDLE);
	assign push      = (state_q == F_PUSH) && !q_stat.full;
	assign push_word = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			dcnt_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_CONV;
						dcnt_q  <= '0;
					end
				end
				F_CONV: begin
					dcnt_q <= dcnt_q + CNT_W'(1);
					if (dcnt_q == CNT_W'(DIGITS - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_stat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// units digit ends up in the top byte so the back end can shift msb first
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			rest_q <= value_to_show;
		end else if (state_q == F_CONV) begin
			rest_q <= quot_ext;
			word_q <= {word_q[WORD_W-SEG_W-1:0], seg_pattern(digit)};
		end
	end

endmodule

@@ src/ssmsd_queue.sv @@
// two-entry queue of pattern words between front and back end
module ssmsd_queue import ssmsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  word_t   push_word,
	input  logic    pop,
	output word_t   pop_word,
	output q_stat_t q_stat
);

	word_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign pop_word     = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

@@ src/ssmsd_back.sv @@
// back end: shifts each pattern word out one bit per cycle with latch and select marks
module ssmsd_back import ssmsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  q_stat_t          q_stat,
	input  word_t            pop_word,
	output logic             pop,
	output logic             strobe,
	output logic             serial_bit,
	output logic             latch_after,
	output logic [SEL_W-1:0] digit_select,
	output logic             last
);

	logic             run_q;
	word_t            sh_q;
	logic [BIT_W-1:0] bit_q;
	logic [DIG_W-1:0] dig_q;

	logic             strobe_q;
	logic             serial_q;
	logic             latch_q;
	logic [SEL_W-1:0] sel_q;
	logic             last_q;

	logic             latch_now;
	logic             final_now;
	logic [SEL_W-1:0] sel_now;

	always_comb begin
		latch_now = (bit_q == BIT_W'(SEG_W - 1));
		final_now = latch_now && (dig_q == DIG_W'(DIGITS - 1));
		for (int j = 0; j < SEL_W; j++) begin
			sel_now[j] = latch_now && (j < SELECT_LINES) && (j < DIGITS)
				&& (dig_q == DIG_W'(j));
		end
	end

	// load a new word when idle, or straight after the final bit of the current one
	assign pop = !q_stat.empty && (!run_q || final_now);

	assign strobe       = strobe_q;
	assign serial_bit   = serial_q;
	assign latch_after  = latch_q;
	assign digit_select = sel_q;
	assign last         = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			bit_q    <= '0;
			dig_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= run_q;
			if (pop) begin
				run_q <= 1'b1;
				bit_q <= '0;
				dig_q <= '0;
			end else if (run_q) begin
				if (final_now) begin
					run_q <= 1'b0;
				end
				bit_q <= bit_q + BIT_W'(1);
				if (latch_now) begin
					dig_q <= dig_q + DIG_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sh_q <= pop_word;
		end else if (run_q) begin
			sh_q <= sh_q << 1;
		end
		serial_q <= sh_q[WORD_W-1];
		latch_q  <= latch_now;
		sel_q    <= sel_now;
		last_q   <= final_now;
	end

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the seven-segment serial driver: directed and random numbers, bit-level checks
`timescale 1ns / 1ps

module tb_top;
	import ssmsd_pkg::*;

	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int ITEMS_PER_MODE = 138;
	localparam int MAX_REPORTS    = 100;

	// segment codes for digits 0..9, msb goes out first
	localparam logic [SEG_W-1:0] SEG_CODES [10] = '{
		8'hDD, 8'h44, 8'hAD, 8'hEC, 8'h74, 8'hF8, 8'hF9, 8'h4C, 8'hFD, 8'hFC
	};

	typedef struct {
		logic             data;
		logic             latch;
		logic [SEL_W-1:0] sel;
		logic             fin;
	} seg_bit_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [VALUE_W-1:0] value_to_show;
	logic               strobe;
	logic               serial_bit;
	logic               latch_after;
	logic [SEL_W-1:0]   digit_select;
	logic               last;

	seg_bit_t pending_bits[$];
	int       sender_idle_pct;
	int       numbers_sent;
	int       bits_checked;
	int       mismatches;
	int       stall_cycles;

	seven_segment_mux_shift_driver_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value_to_show(value_to_show),
		.strobe       (strobe),
		.serial_bit   (serial_bit),
		.latch_after  (latch_after),
		.digit_select (digit_select),
		.last         (last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// expand one number into its 40 serial bits, units digit first
	task automatic queue_segment_bits(input logic [VALUE_W-1:0] value);
		int unsigned rest;
		int unsigned digit;
		logic [SEG_W-1:0] code;
		logic [SEL_W-1:0] line;
		seg_bit_t sb;
		rest = value;
		for (int k = 0; k < DIGITS; k++) begin
			digit = rest % 10;
			rest = rest / 10;
			code = SEG_CODES[digit];
			line = (k < SELECT_LINES && k < SEL_W) ? SEL_W'(1 << k) : '0;
			for (int b = SEG_W - 1; b >= 0; b--) begin
				sb.data  = code[b];
				sb.latch = (b == 0);
				sb.sel   = (b == 0) ? line : '0;
				sb.fin   = (b == 0) && (k == DIGITS - 1);
				pending_bits.push_back(sb);
			end
		end
	endtask

	task automatic report_mismatch(input string field, input int exp_v, input int act_v);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_value(input logic [VALUE_W-1:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		value_to_show = value;
		do @(posedge clk); while (busy);
		queue_segment_bits(value);
		numbers_sent++;
		@(negedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] random_value();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 7)
			return VALUE_W'($urandom_range(99999));
		else if (pick < 9)
			return VALUE_W'($urandom_range((1 << VALUE_W) - 1, 100000));
		return VALUE_W'($urandom_range(99));
	endfunction

	task automatic run_random_numbers(input int count);
		for (int i = 0; i < count; i++)
			send_value(random_value());
	endtask

	task automatic test_directed_values();
		logic [VALUE_W-1:0] vals [] = '{
			0, 1, 9, 10, 100, 1000, 10000, 12345, 67890, 88888, 99999,
			100000, 123456, 65536, 131071, 54321, 9876
		};
		sender_idle_pct = 0;
		foreach (vals[i])
			send_value(vals[i]);
	endtask

	// hold start low until every bit owed has come out, then go again
	task automatic test_drain_pause();
		start = 1'b0;
		while (pending_bits.size() != 0)
			@(negedge clk);
		sender_idle_pct = 0;
		send_value(VALUE_W'(31415));
		send_value(VALUE_W'(27182));
	endtask

	task automatic test_sender_light_idle();
		sender_idle_pct = 25;
		run_random_numbers(ITEMS_PER_MODE);
	endtask

	task automatic test_sender_heavy_idle();
		sender_idle_pct = 69;
		run_random_numbers(ITEMS_PER_MODE);
	endtask

	task automatic test_back_to_back();
		sender_idle_pct = 0;
		run_random_numbers(ITEMS_PER_MODE);
	endtask

	// one bit per strobe, no backpressure possible
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_bits.size() == 0) begin
				report_mismatch("unexpected strobe", 0, 1);
			end else begin
				seg_bit_t sb;
				sb = pending_bits.pop_front();
				bits_checked++;
				if (serial_bit !== sb.data)
					report_mismatch("serial_bit", sb.data, serial_bit);
				if (latch_after !== sb.latch)
					report_mismatch("latch_after", sb.latch, latch_after);
				if (digit_select !== sb.sel)
					report_mismatch("digit_select", sb.sel, digit_select);
				if (last !== sb.fin)
					report_mismatch("last", sb.fin, last);
			end
		end
	end

	// watchdog: cycles with neither an input transfer nor an output bit
	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (strobe === 1'b1 || (start === 1'b1 && busy === 1'b0))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value_to_show = '0;
		sender_idle_pct = 0;
		numbers_sent = 0;
		bits_checked = 0;
		mismatches = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_values();
		test_drain_pause();
		test_sender_light_idle();
		test_sender_heavy_idle();
		test_back_to_back();

		start = 1'b0;
		while (pending_bits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d numbers (directed edges, out-of-range values, idle and back-to-back)",
			numbers_sent);
		$display("checked %0d serial bits, %0d mismatches", bits_checked, mismatches);
		if (mismatches == 0 && pending_bits.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
